FILE: design/blpc_pkg.sv
package blpc_pkg;

  // Field widths of the stream beats.
  localparam int unsigned LevelW = 3;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned HoldW  = 7;
  localparam int unsigned BattW  = 3;
  localparam int unsigned EventW = 2;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;

  // Level handling.
  localparam logic [LevelW-1:0] LevelOff = LevelW'(0);
  localparam logic [LevelW-1:0] LevelOne = LevelW'(1);
  localparam logic [LevelW-1:0] LevelTop = LevelW'(4);
  localparam logic [DutyW-1:0]  LevelStride = DutyW'(5);

  // Battery steps that earn the ceiling boost.
  localparam logic [BattW-1:0] BattBoostLo = BattW'(1);
  localparam logic [BattW-1:0] BattBoostHi = BattW'(2);

  // Register values after reset.
  localparam logic [HoldW-1:0] RstLongPressTicks  = HoldW'(100);
  localparam logic [HoldW-1:0] RstShortPressTicks = HoldW'(8);
  localparam logic [DutyW-1:0] RstStartDuty       = DutyW'(125);
  localparam logic [DutyW-1:0] RstRampStep        = DutyW'(10);
  localparam logic [DutyW-1:0] RstBaseCeiling     = DutyW'(70);
  localparam logic [DutyW-1:0] RstLongPressCeil   = DutyW'(105);
  localparam logic [DutyW-1:0] RstBatteryBoost    = DutyW'(4);
  localparam logic [DutyW-1:0] RstBoostLimit      = DutyW'(124);

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_LONG_PRESS_TICKS   = 3'd0,
    CFG_SHORT_PRESS_TICKS  = 3'd1,
    CFG_START_DUTY         = 3'd2,
    CFG_RAMP_STEP          = 3'd3,
    CFG_BASE_CEILING       = 3'd4,
    CFG_LONG_PRESS_CEILING = 3'd5,
    CFG_BATTERY_BOOST      = 3'd6,
    CFG_BOOST_LIMIT        = 3'd7
  } cfg_index_e;

  // Decoded button events.
  typedef enum logic [EventW-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_e;

  // Clamp a nine-bit sum to the eight-bit duty range.
  function automatic logic [DutyW-1:0] sat8(input logic [DutyW:0] v);
    sat8 = v[DutyW] ? {DutyW{1'b1}} : v[DutyW-1:0];
  endfunction

endpackage

FILE: design/button_power_level_controller.sv
// Latency: the result beat of an accepted input beat is registered and valid in the cycle after it.
// Throughput: one tick per cycle; the single output register is refilled in
// the cycle it is taken, so the input stalls only while the output stalls.
// Reset: asynchronous, active low; all tick state clears to zero, the
// configuration registers return to their defaults and no result is held.
module button_power_level_controller import blpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Input ticks.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] key_down, [1] charger_present, [4:2] battery_step, [7:5] zero
  input  logic [InDataW-1:0]   s_axis_tdata,
  // Results.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [2:0] power_level, [10:3] pwm_duty, [11] pwm_enable, [13:12] press_event,
  // [15:14] zero
  output logic [OutDataW-1:0]  m_axis_tdata
);

  // Configuration registers.
  logic [HoldW-1:0] long_ticks_q, short_ticks_q;
  logic [DutyW-1:0] start_duty_q, ramp_step_q, base_ceil_q;
  logic [DutyW-1:0] long_ceil_q, boost_q, boost_limit_q;

  // Tick state.
  logic [HoldW-1:0]  hold_q, hold_d;
  logic              latched_q, latched_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [DutyW-1:0]  ceil_q, ceil_d;
  logic [DutyW-1:0]  ramp_q, ramp_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic              running_q, running_d;
  logic              charge_q, charge_d;
  press_event_e      event_d;

  // Output register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic in_fire;
  logic key_down, charger_present;
  logic [BattW-1:0] battery_step;

  assign key_down        = s_axis_tdata[0];
  assign charger_present = s_axis_tdata[1];
  assign battery_step    = s_axis_tdata[BattW+1:2];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q  <= RstLongPressTicks;
      short_ticks_q <= RstShortPressTicks;
      start_duty_q  <= RstStartDuty;
      ramp_step_q   <= RstRampStep;
      base_ceil_q   <= RstBaseCeiling;
      long_ceil_q   <= RstLongPressCeil;
      boost_q       <= RstBatteryBoost;
      boost_limit_q <= RstBoostLimit;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LONG_PRESS_TICKS:   long_ticks_q  <= cfg_data_i[HoldW-1:0];
        CFG_SHORT_PRESS_TICKS:  short_ticks_q <= cfg_data_i[HoldW-1:0];
        CFG_START_DUTY:         start_duty_q  <= cfg_data_i;
        CFG_RAMP_STEP:          ramp_step_q   <= cfg_data_i;
        CFG_BASE_CEILING:       base_ceil_q   <= cfg_data_i;
        CFG_LONG_PRESS_CEILING: long_ceil_q   <= cfg_data_i;
        CFG_BATTERY_BOOST:      boost_q       <= cfg_data_i;
        CFG_BOOST_LIMIT:        boost_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One tick: button decode, level change, ramp, then the charger override.
  always_comb begin
    logic [HoldW:0]    hold_inc;
    logic [DutyW-1:0]  offset;
    logic [DutyW-1:0]  lvl_ceil;
    logic [LevelW-1:0] next_level;
    logic              boost_ok;

    hold_d     = hold_q;
    latched_d  = latched_q;
    level_d    = level_q;
    ceil_d     = ceil_q;
    ramp_d     = ramp_q;
    duty_d     = duty_q;
    running_d  = running_q;
    event_d    = EV_NONE;
    hold_inc   = {1'b0, hold_q} + (HoldW+1)'(1);
    next_level = (level_q >= LevelTop) ? LevelOff : level_q + LevelW'(1);
    offset     = DutyW'(LevelStride * DutyW'(next_level - LevelW'(1)));
    lvl_ceil   = sat8({1'b0, base_ceil_q} + {1'b0, offset});
    boost_ok   = (battery_step == BattBoostLo || battery_step == BattBoostHi)
                 && (lvl_ceil < boost_limit_q);

    // Debounce; the button is ignored on the tick after a charger was seen.
    if (!charge_q) begin
      if (key_down) begin
        if (hold_inc >= {1'b0, long_ticks_q}) begin
          hold_d = long_ticks_q;
          if (!latched_q) begin
            latched_d = 1'b1;
            event_d   = EV_LONG;
          end
        end else begin
          hold_d = hold_inc[HoldW-1:0];
        end
      end else begin
        hold_d = '0;
        if (hold_q >= long_ticks_q) begin
          latched_d = 1'b0;
        end else if (hold_q >= short_ticks_q) begin
          event_d = EV_SHORT;
        end
      end
    end

    // Level changes from the decoded press.
    case (event_d)
      EV_SHORT: begin
        level_d = next_level;
        if (next_level == LevelOff) begin
          running_d = 1'b0;
        end else begin
          ceil_d = boost_ok ? sat8({1'b0, lvl_ceil} + {1'b0, boost_q}) : lvl_ceil;
          if (next_level == LevelOne) begin
            ramp_d = start_duty_q;
            duty_d = start_duty_q;
          end else begin
            duty_d = ceil_d;
          end
          running_d = 1'b1;
        end
      end
      EV_LONG: begin
        if (level_q != LevelOff) begin
          level_d   = LevelOff;
          running_d = 1'b0;
        end else begin
          level_d   = LevelOne;
          duty_d    = start_duty_q;
          ceil_d    = long_ceil_q;
          ramp_d    = start_duty_q;
          running_d = 1'b1;
        end
      end
      default: ;
    endcase

    // Soft-start ramp down toward the ceiling, floored at zero.
    if (level_d != LevelOff && ramp_d > ceil_d) begin
      ramp_d = (ramp_d > ramp_step_q) ? ramp_d - ramp_step_q : '0;
      duty_d = ramp_d;
    end

    // A charger forces the unit off.
    charge_d = charger_present;
    if (charger_present) begin
      level_d   = LevelOff;
      running_d = 1'b0;
    end
  end

  // Tick state advances on each accepted input beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= '0;
      latched_q <= 1'b0;
      level_q   <= '0;
      ceil_q    <= '0;
      ramp_q    <= '0;
      duty_q    <= '0;
      running_q <= 1'b0;
      charge_q  <= 1'b0;
    end else if (in_fire) begin
      hold_q    <= hold_d;
      latched_q <= latched_d;
      level_q   <= level_d;
      ceil_q    <= ceil_d;
      ramp_q    <= ramp_d;
      duty_q    <= duty_d;
      running_q <= running_d;
      charge_q  <= charge_d;
    end
  end

  // Output beat valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {2'b00, event_d, running_d, duty_d, level_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
